// ===== rtl/mnpp_pkg.sv =====
// shared types and constants for the monophonic note priority block
package mnpp_pkg;

    localparam int KEY_W   = 6;
    localparam int NOTE_W  = 7;
    localparam int VALUE_W = 7;
    localparam int RATE_W  = 16;
    localparam int PROG_W  = 17;
    localparam int VEL_W   = 8;
    localparam int SEL_W   = 4;

    localparam logic [NOTE_W-1:0] CC_GLIDE_TIME     = 7'd5;
    localparam logic [NOTE_W-1:0] CC_ALL_OFF        = 7'd123;
    localparam logic [NOTE_W-1:0] LOWEST_NOTE_RESET = 7'd36;
    localparam logic [RATE_W-1:0] RATE_NUMERATOR    = 16'd51200;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_CONTROL  = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_SPREAD,
        CELL_CLOSE,
        CELL_OPEN
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPREAD,
        ST_UPDATE,
        ST_FINISH,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        cell_op_t           op;
        logic [KEY_W-1:0]   search_key;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [NOTE_W-1:0]  number;
        logic [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic               drive_update;
        logic               octave_high;
        logic               mux_low_enable;
        logic               mux_high_enable;
        logic [SEL_W-1:0]   note_select;
        logic               velocity_update;
        logic [VEL_W-1:0]   velocity_level;
    } result_t;

endpackage

// ===== rtl/mnpp_key_cell.sv =====
// one slot of the held-key row, newest key at the left end
module mnpp_key_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mnpp_pkg::cell_ctl_t          ctl,
    input  logic                         occupied,
    input  logic [mnpp_pkg::KEY_W-1:0]   left_key,
    input  logic [mnpp_pkg::KEY_W-1:0]   right_key,
    input  logic                         left_kill,
    output logic [mnpp_pkg::KEY_W-1:0]   key,
    output logic                         kill
);

    logic [mnpp_pkg::KEY_W-1:0] key_reg;
    logic [mnpp_pkg::KEY_W-1:0] key_next;
    logic                       kill_reg;
    logic                       kill_next;
    logic                       match;

    // local compare against the broadcast key
    assign match = occupied && (key_reg == ctl.search_key);

    // next contents of the slot
    always_comb
    begin
        key_next  = key_reg;
        kill_next = kill_reg;
        case (ctl.op)
            mnpp_pkg::CELL_HOLD:
            begin
            end
            mnpp_pkg::CELL_MATCH:  kill_next = match;
            mnpp_pkg::CELL_SPREAD: kill_next = kill_reg | left_kill;
            mnpp_pkg::CELL_CLOSE:
            begin
                if (kill_reg)
                begin
                    key_next = right_key;
                end
            end
            mnpp_pkg::CELL_OPEN:   key_next = left_key;
            default:
            begin
            end
        endcase
    end

    // key payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // removal mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kill_reg <= 1'b0;
        end
        else
        begin
            kill_reg <= kill_next;
        end
    end

    assign key  = key_reg;
    assign kill = kill_reg;

endmodule

// ===== rtl/mnpp_rate_div.sv =====
// bit-serial restoring divider for the glide rate, numerator fixed
module mnpp_rate_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mnpp_pkg::VALUE_W-1:0]  divisor,
    output logic                          done,
    output logic [mnpp_pkg::RATE_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(mnpp_pkg::RATE_W);

    logic                          active_reg;
    logic                          active_next;
    logic                          done_reg;
    logic                          done_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [mnpp_pkg::VALUE_W-1:0]  divisor_reg;
    logic [mnpp_pkg::VALUE_W-1:0]  divisor_next;
    logic [mnpp_pkg::VALUE_W-1:0]  rem_reg;
    logic [mnpp_pkg::VALUE_W-1:0]  rem_next;
    logic [mnpp_pkg::RATE_W-1:0]   quo_reg;
    logic [mnpp_pkg::RATE_W-1:0]   quo_next;
    logic [mnpp_pkg::VALUE_W:0]    rem_shift;
    logic [mnpp_pkg::VALUE_W:0]    rem_diff;
    logic                          fits;

    // one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[mnpp_pkg::RATE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        active_next  = active_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        if (start)
        begin
            active_next  = 1'b1;
            cnt_next     = '0;
            divisor_next = divisor;
            rem_next     = '0;
            quo_next     = mnpp_pkg::RATE_NUMERATOR;
        end
        else if (active_reg)
        begin
            rem_next = fits ? rem_diff[mnpp_pkg::VALUE_W-1:0]
                            : rem_shift[mnpp_pkg::VALUE_W-1:0];
            quo_next = {quo_reg[mnpp_pkg::RATE_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(mnpp_pkg::RATE_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/mono_note_priority_portamento.sv =====
// monophonic last-note-priority key stack with glide, top level
//
// Commands arrive on request and transfer at a clock edge where start is high
// and busy is low. Each command gives exactly one result, shown on result for
// a single cycle with done high; the receiver takes it in that cycle and
// cannot hold it off. lowest_note is written through cfg_we / cfg_data; the
// user must write it only while the block is idle; the block does not enforce this.
// Held keys live in a row of KEY_SLOTS cells, newest at the left end. A note
// on or note off loads a compare in every cell, lets the removal mark ripple
// one cell per cycle along the row, then shifts the row at most once before
// its result is shown. A glide-time control with a nonzero value runs the
// serial divider and answers when the quotient is done.
// Ticks, other controls and ignored notes answer in the next cycle.
// busy is high while an in-range note or nonzero glide-time command is in
// progress; the next command may transfer in the cycle its result is shown.
// After reset the stack is empty, glide rate, glide position, sounding note
// and velocity are zero and lowest_note is 36.
module mono_note_priority_portamento #(
    parameter int KEY_SLOTS    = 48,
    parameter int OCTAVE_SPLIT = 24,
    parameter int MUX_WIDTH    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mnpp_pkg::request_t            request,
    output logic                          done,
    output mnpp_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [mnpp_pkg::NOTE_W-1:0]   cfg_data
);

    localparam int CNT_W    = $clog2(KEY_SLOTS + 1);
    localparam int SPREAD_W = $clog2(KEY_SLOTS);
    localparam int KW       = mnpp_pkg::KEY_W;

    mnpp_pkg::state_t             state_reg;
    mnpp_pkg::state_t             state_next;
    logic [SPREAD_W-1:0]          spread_cnt_reg;
    logic [SPREAD_W-1:0]          spread_cnt_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [mnpp_pkg::RATE_W-1:0]  rate_reg;
    logic [mnpp_pkg::RATE_W-1:0]  rate_next;
    logic [mnpp_pkg::PROG_W-1:0]  progress_reg;
    logic [mnpp_pkg::PROG_W-1:0]  progress_next;
    logic [KW-1:0]                sounding_reg;
    logic [KW-1:0]                sounding_next;
    logic [mnpp_pkg::VEL_W-1:0]   velocity_reg;
    logic [mnpp_pkg::VEL_W-1:0]   velocity_next;
    logic [mnpp_pkg::NOTE_W-1:0]  lowest_note_reg;
    logic [mnpp_pkg::NOTE_W-1:0]  lowest_note_next;
    logic                         is_on_reg;
    logic                         is_on_next;
    logic [KW-1:0]                item_key_reg;
    logic [KW-1:0]                item_key_next;
    mnpp_pkg::result_t            pend_reg;
    mnpp_pkg::result_t            pend_next;
    logic                         done_reg;
    logic                         done_next;
    mnpp_pkg::result_t            result_reg;
    mnpp_pkg::result_t            result_next;

    logic                         accept;
    logic [mnpp_pkg::NOTE_W-1:0]  note_diff;
    logic                         in_range;
    logic [KW-1:0]                req_key;
    mnpp_pkg::cell_ctl_t          cell_ctl;
    logic [KW-1:0]                cell_key  [KEY_SLOTS];
    logic                         cell_kill [KEY_SLOTS];
    logic                         found;
    logic                         div_start;
    logic                         div_done;
    logic [mnpp_pkg::RATE_W-1:0]  div_quotient;
    logic [mnpp_pkg::PROG_W:0]    prog_sum;
    logic                         step_bit;
    logic [KW-1:0]                target;
    logic [KW-1:0]                key_gap;
    logic                         emit;
    mnpp_pkg::result_t            res;

    // pitch to octave bit, multiplexer choice and select lines
    function automatic mnpp_pkg::result_t drive_pitch(input logic [KW-1:0] k);
        mnpp_pkg::result_t r;
        logic [KW-1:0]     n;
        logic [KW-1:0]     hi;
        r              = '0;
        r.drive_update = 1'b1;
        n              = k;
        if (n >= KW'(OCTAVE_SPLIT))
        begin
            r.octave_high = 1'b1;
            n             = n - KW'(OCTAVE_SPLIT);
        end
        hi = n - KW'(MUX_WIDTH);
        if (n < KW'(MUX_WIDTH))
        begin
            r.mux_low_enable = 1'b1;
            r.note_select    = n[mnpp_pkg::SEL_W-1:0];
        end
        else
        begin
            r.mux_high_enable = 1'b1;
            r.note_select     = hi[mnpp_pkg::SEL_W-1:0];
        end
        return r;
    endfunction

    // command transfer and key index
    assign accept    = start && !busy;
    assign busy      = (state_reg != mnpp_pkg::ST_IDLE);
    assign note_diff = request.number - lowest_note_reg;
    assign in_range  = (request.number >= lowest_note_reg) &&
                       ({1'b0, note_diff} < (mnpp_pkg::NOTE_W + 1)'(KEY_SLOTS));
    assign req_key   = note_diff[KW-1:0];

    // row of key cells
    generate
        for (genvar i = 0; i < KEY_SLOTS; i++)
        begin : g_cell
            logic [KW-1:0] left_key;
            logic [KW-1:0] right_key;
            logic          left_kill;
            logic          occupied;
            if (i == 0)
            begin : g_first
                assign left_key  = cell_ctl.search_key;
                assign left_kill = 1'b0;
            end
            else
            begin : g_inner
                assign left_key  = cell_key[i-1];
                assign left_kill = cell_kill[i-1];
            end
            if (i == KEY_SLOTS - 1)
            begin : g_last
                assign right_key = cell_key[i];
            end
            else
            begin : g_mid
                assign right_key = cell_key[i+1];
            end
            assign occupied = (count_reg > CNT_W'(i));
            mnpp_key_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .occupied  (occupied),
                .left_key  (left_key),
                .right_key (right_key),
                .left_kill (left_kill),
                .key       (cell_key[i]),
                .kill      (cell_kill[i])
            );
        end
    endgenerate

    // after the ripple the last mark tells whether the key is held
    assign found = cell_kill[KEY_SLOTS-1];

    // glide rate divider
    mnpp_rate_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (request.value),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // glide accumulator step
    assign prog_sum = {1'b0, progress_reg} + {2'b0, rate_reg};
    assign step_bit = prog_sum[mnpp_pkg::RATE_W];
    assign target   = cell_key[0];
    assign key_gap  = (target > sounding_reg) ? (target - sounding_reg)
                                              : (sounding_reg - target);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mnpp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((request.command == mnpp_pkg::CMD_NOTE_ON ||
                         request.command == mnpp_pkg::CMD_NOTE_OFF) && in_range)
                    begin
                        state_next = mnpp_pkg::ST_SPREAD;
                    end
                    else if (request.command == mnpp_pkg::CMD_CONTROL &&
                             request.number == mnpp_pkg::CC_GLIDE_TIME &&
                             request.value != '0)
                    begin
                        state_next = mnpp_pkg::ST_DIVIDE;
                    end
                end
            end
            mnpp_pkg::ST_SPREAD:
            begin
                if (spread_cnt_reg == SPREAD_W'(KEY_SLOTS - 2))
                begin
                    state_next = mnpp_pkg::ST_UPDATE;
                end
            end
            mnpp_pkg::ST_UPDATE: state_next = mnpp_pkg::ST_FINISH;
            mnpp_pkg::ST_FINISH: state_next = mnpp_pkg::ST_IDLE;
            mnpp_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = mnpp_pkg::ST_IDLE;
                end
            end
            default: state_next = mnpp_pkg::ST_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        spread_cnt_next     = spread_cnt_reg;
        count_next          = count_reg;
        rate_next           = rate_reg;
        progress_next       = progress_reg;
        sounding_next       = sounding_reg;
        velocity_next       = velocity_reg;
        lowest_note_next    = cfg_we ? cfg_data : lowest_note_reg;
        is_on_next          = is_on_reg;
        item_key_next       = item_key_reg;
        pend_next           = pend_reg;
        cell_ctl.op         = mnpp_pkg::CELL_HOLD;
        cell_ctl.search_key = item_key_reg;
        div_start           = 1'b0;
        emit                = 1'b0;
        res                 = '0;
        done_next           = 1'b0;
        result_next         = result_reg;
        case (state_reg)
            mnpp_pkg::ST_IDLE:
            begin
                cell_ctl.search_key = req_key;
                if (accept)
                begin
                    item_key_next   = req_key;
                    is_on_next      = (request.command == mnpp_pkg::CMD_NOTE_ON);
                    spread_cnt_next = '0;
                    case (request.command)
                        mnpp_pkg::CMD_NOTE_ON:
                        begin
                            if (in_range)
                            begin
                                velocity_next = {request.value, 1'b0};
                                cell_ctl.op   = mnpp_pkg::CELL_MATCH;
                                if (rate_reg == '0)
                                begin
                                    sounding_next = req_key;
                                    pend_next     = drive_pitch(req_key);
                                end
                                else
                                begin
                                    pend_next = drive_pitch(sounding_reg);
                                end
                                pend_next.velocity_update = 1'b1;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        mnpp_pkg::CMD_NOTE_OFF:
                        begin
                            if (in_range)
                            begin
                                cell_ctl.op = mnpp_pkg::CELL_MATCH;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        mnpp_pkg::CMD_CONTROL:
                        begin
                            if (request.number == mnpp_pkg::CC_GLIDE_TIME)
                            begin
                                if (request.value == '0)
                                begin
                                    rate_next = '0;
                                    emit      = 1'b1;
                                end
                                else
                                begin
                                    div_start = 1'b1;
                                end
                            end
                            else if (request.number == mnpp_pkg::CC_ALL_OFF)
                            begin
                                count_next       = '0;
                                res.drive_update = 1'b1;
                                emit             = 1'b1;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        mnpp_pkg::CMD_TICK:
                        begin
                            emit = 1'b1;
                            if (count_reg != '0)
                            begin
                                progress_next = prog_sum[mnpp_pkg::PROG_W-1:0];
                                if (step_bit)
                                begin
                                    if (sounding_reg != target)
                                    begin
                                        if ({{(KW-1){1'b0}}, step_bit} > key_gap)
                                        begin
                                            sounding_next = target;
                                        end
                                        else if (target > sounding_reg)
                                        begin
                                            sounding_next = sounding_reg + KW'(step_bit);
                                        end
                                        else
                                        begin
                                            sounding_next = sounding_reg - KW'(step_bit);
                                        end
                                        res = drive_pitch(sounding_next);
                                    end
                                    progress_next = {1'b0, prog_sum[mnpp_pkg::RATE_W-1:0]};
                                end
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            mnpp_pkg::ST_SPREAD:
            begin
                cell_ctl.op     = mnpp_pkg::CELL_SPREAD;
                spread_cnt_next = spread_cnt_reg + 1'b1;
            end
            mnpp_pkg::ST_UPDATE:
            begin
                if (is_on_reg)
                begin
                    if (!found && count_reg < CNT_W'(KEY_SLOTS))
                    begin
                        cell_ctl.op = mnpp_pkg::CELL_OPEN;
                        count_next  = count_reg + 1'b1;
                    end
                end
                else if (found)
                begin
                    cell_ctl.op = mnpp_pkg::CELL_CLOSE;
                    count_next  = count_reg - 1'b1;
                end
            end
            mnpp_pkg::ST_FINISH:
            begin
                emit = 1'b1;
                if (is_on_reg)
                begin
                    res = pend_reg;
                end
                else if (count_reg != '0)
                begin
                    res = drive_pitch(cell_key[0]);
                end
                else
                begin
                    res.drive_update = 1'b1;
                end
            end
            mnpp_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    rate_next = div_quotient;
                    emit      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // one result transfer per command
        if (emit)
        begin
            done_next                  = 1'b1;
            result_next                = res;
            result_next.velocity_level = velocity_next;
        end
    end

    // control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mnpp_pkg::ST_IDLE;
            spread_cnt_reg  <= '0;
            count_reg       <= '0;
            rate_reg        <= '0;
            progress_reg    <= '0;
            sounding_reg    <= '0;
            velocity_reg    <= '0;
            lowest_note_reg <= mnpp_pkg::LOWEST_NOTE_RESET;
            is_on_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            spread_cnt_reg  <= spread_cnt_next;
            count_reg       <= count_next;
            rate_reg        <= rate_next;
            progress_reg    <= progress_next;
            sounding_reg    <= sounding_next;
            velocity_reg    <= velocity_next;
            lowest_note_reg <= lowest_note_next;
            is_on_reg       <= is_on_next;
            done_reg        <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_key_reg <= item_key_next;
        pend_reg     <= pend_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
